// ===== src/srab_pkg.sv =====
package srab_pkg;

	localparam logic [7:0]  CMD_READ    = 8'h01;
	localparam logic [7:0]  CMD_WRITE   = 8'h02;
	localparam logic [31:0] ADDR_LED    = 32'h0000_0000;
	localparam logic [31:0] ADDR_SWITCH = 32'h0000_0004;

	localparam int FRAME_LAST_IDX = 8;
	localparam int REPLY_LAST_IDX = 4;
	localparam int QUEUE_DEPTH    = 2;
	localparam int QUEUE_PTR_W    = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W    = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BAD_CMD  = 2'd1,
		ST_BAD_ADDR = 2'd2,
		ST_RO       = 2'd3
	} status_t;

	typedef enum logic {
		BK_IDLE,
		BK_SEND
	} back_state_t;

	typedef struct packed {
		logic [7:0]  command;
		logic [31:0] address;
		logic [31:0] data;
		logic        switch_a;
		logic        switch_b;
	} req_t;

	typedef struct packed {
		logic                   full;
		logic                   empty;
		logic [QUEUE_CNT_W-1:0] count;
	} queue_stat_t;

endpackage

// ===== src/serial_register_access_slave.sv =====
// Channel   Dir  Payload                                       Transfer
// s_axis    in   tdata: rx_byte, switch_a, switch_b            tvalid && tready
// m_axis    out  tdata: tx_byte, led_a_drive, led_b_drive;     tvalid && tready
//                tlast: last_byte
//
// Request bytes are taken one per cycle; the ninth byte of a frame waits only
// when the two-entry request queue is full.
// Each request is executed in BK_IDLE as it is popped, and its five reply bytes are
// then sent through the output register in BK_SEND; the next request is popped only once the last reply byte is loaded.
// Reset clears the byte counter, the request queue, the reply sequencer and the
// LED state (both off).
// A stalled output holds the back end, while the front keeps taking bytes until the request queue is full.
module serial_register_access_slave (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // rx_byte[7:0], switch_a, switch_b, zeros
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // tx_byte[7:0], led_a_drive, led_b_drive, zeros
	output logic        m_axis_tlast
);

	srab_pkg::req_t        push_req;
	srab_pkg::req_t        head;
	srab_pkg::queue_stat_t qstat;
	logic                  push;
	logic                  pop;
	logic [7:0]            tx_byte;
	logic                  led_a_drive;
	logic                  led_b_drive;

	srab_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.rx_byte    (s_axis_tdata[7:0]),
		.switch_a   (s_axis_tdata[8]),
		.switch_b   (s_axis_tdata[9]),
		.push       (push),
		.queue_full (qstat.full),
		.push_req   (push_req)
	);

	srab_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_req (push_req),
		.pop      (pop),
		.head     (head),
		.stat     (qstat)
	);

	srab_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (!qstat.empty),
		.req         (head),
		.pop         (pop),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.tx_byte     (tx_byte),
		.last_byte   (m_axis_tlast),
		.led_a_drive (led_a_drive),
		.led_b_drive (led_b_drive)
	);

	assign m_axis_tdata = {6'd0, led_b_drive, led_a_drive, tx_byte};

`ifndef SYNTH
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		qstat.count <= srab_pkg::QUEUE_CNT_W'(srab_pkg::QUEUE_DEPTH))
		else $error("request queue count out of range");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> qstat.full)
		else $error("input stalled while queue has room");

	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !qstat.full)
		else $error("request pushed into a full queue");

	a_led_stable_in_reply: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tlast) |=> $stable(m_axis_tdata[9:8]))
		else $error("LED level changed within a reply");
`endif

endmodule

// ===== src/srab_front.sv =====
module srab_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         rx_byte,
	input  logic               switch_a,
	input  logic               switch_b,
	output logic               push,
	input  logic               queue_full,
	output srab_pkg::req_t     push_req
);

	logic [3:0]  byte_index_q;
	logic [7:0]  command_q;
	logic [31:0] address_q;
	logic [23:0] data_q;
	logic        closing;
	logic        take;

	assign closing  = (byte_index_q == 4'(srab_pkg::FRAME_LAST_IDX));
	assign in_ready = !closing || !queue_full;
	assign take     = in_valid && in_ready;
	assign push     = take && closing;

	assign push_req.command  = command_q;
	assign push_req.address  = address_q;
	assign push_req.data     = {data_q, rx_byte};
	assign push_req.switch_a = switch_a;
	assign push_req.switch_b = switch_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_index_q <= '0;
			command_q    <= '0;
			address_q    <= '0;
			data_q       <= '0;
		end else if (take) begin
			if (closing) begin
				byte_index_q <= '0;
			end else begin
				byte_index_q <= byte_index_q + 4'd1;
			end
			if (byte_index_q == 4'd0) begin
				command_q <= rx_byte;
			end else if (byte_index_q <= 4'd4) begin
				address_q <= {address_q[23:0], rx_byte};
			end else if (!closing) begin
				data_q <= {data_q[15:0], rx_byte};
			end
		end
	end

endmodule

// ===== src/srab_queue.sv =====
module srab_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  srab_pkg::req_t        push_req,
	input  logic                  pop,
	output srab_pkg::req_t        head,
	output srab_pkg::queue_stat_t stat
);

	srab_pkg::req_t                      entry_q [srab_pkg::QUEUE_DEPTH];
	logic [srab_pkg::QUEUE_PTR_W-1:0]    wr_ptr_q;
	logic [srab_pkg::QUEUE_PTR_W-1:0]    rd_ptr_q;
	logic [srab_pkg::QUEUE_CNT_W-1:0]    count_q;
	logic                                do_push;
	logic                                do_pop;

	assign stat.count = count_q;
	assign stat.full  = (count_q == srab_pkg::QUEUE_CNT_W'(srab_pkg::QUEUE_DEPTH));
	assign stat.empty = (count_q == '0);
	assign head       = entry_q[rd_ptr_q];
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == srab_pkg::QUEUE_PTR_W'(srab_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == srab_pkg::QUEUE_PTR_W'(srab_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + srab_pkg::QUEUE_CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - srab_pkg::QUEUE_CNT_W'(1);
			end
		end
	end

endmodule

// ===== src/srab_back.sv =====
module srab_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  srab_pkg::req_t req,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [7:0]     tx_byte,
	output logic           last_byte,
	output logic           led_a_drive,
	output logic           led_b_drive
);

	srab_pkg::back_state_t state_q;
	srab_pkg::back_state_t state_d;
	srab_pkg::status_t     status_q;
	srab_pkg::status_t     status_d;
	logic [31:0]           word_q;
	logic [31:0]           word_d;
	logic [2:0]            cnt_q;
	logic                  led_a_q;
	logic                  led_b_q;
	logic                  led_a_d;
	logic                  led_b_d;
	logic                  out_valid_q;
	logic [7:0]            out_byte_q;
	logic                  out_last_q;
	logic                  out_led_a_q;
	logic                  out_led_b_q;
	logic                  load_out;
	logic                  start;
	logic                  emit;
	logic                  reply_done;
	logic [7:0]            next_byte;

	assign load_out    = !out_valid_q || out_ready;
	assign reply_done  = (cnt_q == 3'(srab_pkg::REPLY_LAST_IDX));
	assign out_valid   = out_valid_q;
	assign tx_byte     = out_byte_q;
	assign last_byte   = out_last_q;
	assign led_a_drive = out_led_a_q;
	assign led_b_drive = out_led_b_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			srab_pkg::BK_IDLE: begin
				if (req_valid) begin
					state_d = srab_pkg::BK_SEND;
				end
			end
			srab_pkg::BK_SEND: begin
				if (load_out && reply_done) begin
					state_d = srab_pkg::BK_IDLE;
				end
			end
			default: state_d = srab_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		pop   = (state_q == srab_pkg::BK_IDLE);
		start = pop && req_valid;
		emit  = (state_q == srab_pkg::BK_SEND) && load_out;
	end

	// A clear bit wins over a set bit for each LED.
	always_comb begin
		status_d = srab_pkg::ST_OK;
		word_d   = '0;
		led_a_d  = led_a_q;
		led_b_d  = led_b_q;
		if (req.command == srab_pkg::CMD_READ) begin
			if (req.address == srab_pkg::ADDR_LED) begin
				word_d = {28'd0, !led_b_q, led_b_q, !led_a_q, led_a_q};
			end else if (req.address == srab_pkg::ADDR_SWITCH) begin
				word_d = {30'd0, req.switch_b, req.switch_a};
			end else begin
				status_d = srab_pkg::ST_BAD_ADDR;
			end
		end else if (req.command == srab_pkg::CMD_WRITE) begin
			word_d = req.data;
			if (req.address == srab_pkg::ADDR_LED) begin
				led_a_d = req.data[1] ? 1'b0 : (req.data[0] ? 1'b1 : led_a_q);
				led_b_d = req.data[3] ? 1'b0 : (req.data[2] ? 1'b1 : led_b_q);
			end else if (req.address == srab_pkg::ADDR_SWITCH) begin
				status_d = srab_pkg::ST_RO;
			end else begin
				status_d = srab_pkg::ST_BAD_ADDR;
			end
		end else begin
			status_d = srab_pkg::ST_BAD_CMD;
		end
	end

	always_comb begin
		unique case (cnt_q)
			3'd0:    next_byte = {6'd0, status_q};
			3'd1:    next_byte = word_q[31:24];
			3'd2:    next_byte = word_q[23:16];
			3'd3:    next_byte = word_q[15:8];
			3'd4:    next_byte = word_q[7:0];
			default: next_byte = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= srab_pkg::BK_IDLE;
			cnt_q       <= '0;
			led_a_q     <= 1'b0;
			led_b_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (start) begin
				cnt_q   <= '0;
				led_a_q <= led_a_d;
				led_b_q <= led_b_d;
			end else if (emit) begin
				cnt_q <= cnt_q + 3'd1;
			end
			if (load_out) begin
				out_valid_q <= emit;
			end
		end
	end

	// The LED levels travel with each reply byte, so a following request
	// cannot change them while a byte of the previous reply still waits.
	always_ff @(posedge clk) begin
		if (start) begin
			status_q <= status_d;
			word_q   <= word_d;
		end
		if (emit) begin
			out_byte_q  <= next_byte;
			out_last_q  <= reply_done;
			out_led_a_q <= led_a_q;
			out_led_b_q <= led_b_q;
		end
	end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

	localparam int STALL_LIMIT  = 1000;
	localparam int TARGET_BYTES = 220;
	localparam int TAIL_CYCLES  = 20;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic       last_byte;
		logic       led_a;
		logic       led_b;
	} reply_byte_t;

	class bridge_tracker;
		int unsigned errors;
		logic [3:0]  byte_idx;
		logic [7:0]  command;
		logic [31:0] address;
		logic [23:0] data_head;
		logic        led_a;
		logic        led_b;
		reply_byte_t expected_replies[$];

		function new();
			errors = 0;
			byte_idx = '0;
			command = '0;
			address = '0;
			data_head = '0;
			led_a = 1'b0;
			led_b = 1'b0;
		endfunction

		function int pending();
			return expected_replies.size();
		endfunction

		function void take_rx_byte(logic [7:0] rx, logic sw_a, logic sw_b);
			logic [31:0]         value;
			logic [31:0]         word;
			srab_pkg::status_t   status;
			int                  k;
			if (byte_idx == 4'd0) begin
				command = rx;
				byte_idx = 4'd1;
			end else if (byte_idx <= 4'd4) begin
				address = {address[23:0], rx};
				byte_idx = byte_idx + 4'd1;
			end else if (byte_idx <= 4'd7) begin
				data_head = {data_head[15:0], rx};
				byte_idx = byte_idx + 4'd1;
			end else begin
				value = {data_head, rx};
				status = srab_pkg::ST_OK;
				word = '0;
				if (command == srab_pkg::CMD_READ) begin
					if (address == srab_pkg::ADDR_LED) begin
						word = {28'd0, ~led_b, led_b, ~led_a, led_a};
					end else if (address == srab_pkg::ADDR_SWITCH) begin
						word = {30'd0, sw_b, sw_a};
					end else begin
						status = srab_pkg::ST_BAD_ADDR;
					end
				end else if (command == srab_pkg::CMD_WRITE) begin
					word = value;
					if (address == srab_pkg::ADDR_LED) begin
						// A clear bit is applied after its set bit, so clearing wins.
						if (value[0]) led_a = 1'b1;
						if (value[1]) led_a = 1'b0;
						if (value[2]) led_b = 1'b1;
						if (value[3]) led_b = 1'b0;
					end else if (address == srab_pkg::ADDR_SWITCH) begin
						status = srab_pkg::ST_RO;
					end else begin
						status = srab_pkg::ST_BAD_ADDR;
					end
				end else begin
					status = srab_pkg::ST_BAD_CMD;
				end
				byte_idx = '0;
				expected_replies.push_back('{{6'd0, status}, 1'b0, led_a, led_b});
				for (k = 3; k >= 0; k--) begin
					expected_replies.push_back('{word[8*k +: 8], k == 0, led_a, led_b});
				end
			end
		endfunction

		function void check_tx_byte(logic [15:0] tdata, logic tlast);
			reply_byte_t want;
			if (expected_replies.size() == 0) begin
				$error("unexpected transfer: tx_byte %h tlast %b", tdata[7:0], tlast);
				errors++;
				return;
			end
			want = expected_replies.pop_front();
			if (tdata[7:0] !== want.tx_byte) begin
				$error("tx_byte: expected %h, actual %h", want.tx_byte, tdata[7:0]);
				errors++;
			end
			if (tlast !== want.last_byte) begin
				$error("last_byte: expected %b, actual %b", want.last_byte, tlast);
				errors++;
			end
			if (tdata[8] !== want.led_a) begin
				$error("led_a_drive: expected %b, actual %b", want.led_a, tdata[8]);
				errors++;
			end
			if (tdata[9] !== want.led_b) begin
				$error("led_b_drive: expected %b, actual %b", want.led_b, tdata[9]);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;
	logic        m_axis_tlast;

	bridge_tracker tracker;
	bit            idle_on;
	int            bytes_sent;
	int            quiet_cycles;

	serial_register_access_slave DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(negedge clk) begin
		m_axis_tready <= idle_on ? ($urandom_range(99) >= 33) : 1'b1;
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			tracker.check_tx_byte(m_axis_tdata, m_axis_tlast);
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_byte(input logic [7:0] rx);
		logic sw_a;
		logic sw_b;
		sw_a = 1'($urandom_range(1));
		sw_b = 1'($urandom_range(1));
		while (idle_on && $urandom_range(99) < 33) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {6'd0, sw_b, sw_a, rx};
		do @(posedge clk); while (!s_axis_tready);
		tracker.take_rx_byte(rx, sw_a, sw_b);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_frame(input logic [7:0] command, input logic [31:0] address,
			input logic [31:0] data);
		int i;
		send_byte(command);
		for (i = 3; i >= 0; i--) send_byte(address[8*i +: 8]);
		for (i = 3; i >= 0; i--) send_byte(data[8*i +: 8]);
	endtask

	task automatic wait_for_replies();
		s_axis_tvalid <= 1'b0;
		while (tracker.pending() != 0) @(negedge clk);
		@(negedge clk);
	endtask

	initial begin
		logic [7:0]  command;
		logic [31:0] address;
		logic [31:0] data;
		int          pick;
		int          n;
		tracker = new();
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		idle_on = 1'b1;
		bytes_sent = 0;
		quiet_cycles = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_frame(srab_pkg::CMD_WRITE, srab_pkg::ADDR_LED, 32'h0000_0005);
		send_frame(8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_frame(srab_pkg::CMD_READ, srab_pkg::ADDR_LED, 32'h0000_0000);
		wait_for_replies();

		while (bytes_sent < TARGET_BYTES) begin
			idle_on = !(bytes_sent >= 100 && bytes_sent < 160);
			if ($urandom_range(99) < 12) begin
				// A broken frame shifts the byte count; pad until it closes again.
				n = $urandom_range(1, 8);
				repeat (n) send_byte(8'($urandom_range(255)));
				while (tracker.byte_idx != 4'd0) send_byte(8'($urandom_range(255)));
			end else begin
				pick = $urandom_range(99);
				command = (pick < 45) ? srab_pkg::CMD_READ :
					(pick < 85) ? srab_pkg::CMD_WRITE : 8'($urandom_range(255));
				pick = $urandom_range(99);
				if (pick < 40) address = srab_pkg::ADDR_LED;
				else if (pick < 70) address = srab_pkg::ADDR_SWITCH;
				else if (pick < 80) address = $urandom_range(1, 7);
				else if (pick < 88) address = 32'hFFFF_FFFF;
				else address = $urandom;
				data = $urandom;
				if ($urandom_range(1) == 1) data[3:0] = 4'($urandom_range(15));
				send_frame(command, address, data);
			end
		end
		s_axis_tvalid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (tracker.errors == 0 && tracker.pending() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
